### rtl/pse_pkg.sv
package pse_pkg;

	localparam int unsigned DIM_W = 15;

	localparam logic [DIM_W-1:0] DIM_MAX = 15'd16384;
	localparam logic [15:0] STORED_BLOCK_MAX = 16'hFFFF;
	localparam logic [15:0] ADLER_MOD = 16'd65521;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// last byte position of each framing sequence
	localparam logic [5:0] HEAD_LAST = 6'd42;
	localparam logic [5:0] TAIL_LAST = 6'd19;
	localparam logic [5:0] BLKHDR_LAST = 6'd4;

	// configuration register indexes
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// one classified pixel byte
	typedef struct packed {
		logic [7:0] data;
		logic first;
		logic row_start;
		logic last;
	} item_t;

	typedef enum logic [2:0] {
		ST_NEXT,
		ST_HEAD,
		ST_FILTER,
		ST_PIXEL,
		ST_TAIL
	} step_t;

	function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### rtl/png_stored_stream_encoder_unit.sv
// Path: a pixel byte passes through the queue and the output register to out_byte; the
// first byte of a file is preceded by the signature, IHDR and IDAT header, each stored
// block by its block header, each row by a filter byte, and the last byte is followed by
// the trailer. The queue keeps taking items while the back emits framing bytes.
// Throughput: the back sequencer emits one byte per cycle while out_byte is empty or popped.
// Reset (arst_n, asynchronous, active low): empties queue and output, width and height 1.
module png_stored_stream_encoder_unit
	import pse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       pixel_byte,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic             file_end
);

	// accepted item from the front, classified
	item_t            f_item, q_item;
	logic             take, q_valid, q_pop;
	logic [DIM_W-1:0] width, height;
	logic [30:0]      raw_len;
	logic [31:0]      idat_len;

	assign take = push && !full;

	// front: hold the dimensions, count columns and rows, mark file start, row start
	// and file end; also work out the raw and IDAT lengths ahead of the first item
	pse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.pixel_byte (pixel_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item       (f_item),
		.width      (width),
		.height     (height),
		.raw_len    (raw_len),
		.idat_len   (idat_len)
	);

	// short queue so the front keeps taking items while the back inserts framing
	pse_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_item (f_item),
		.full    (full),
		.rd      (q_pop),
		.rd_item (q_item),
		.valid   (q_valid)
	);

	// back: emit one byte per cycle while the output can take it, advance CRC-32 and Adler-32,
	// drop the item from the queue once its last byte is out
	pse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.item_valid (q_valid),
		.item_pop   (q_pop),
		.width      (width),
		.height     (height),
		.raw_len    (raw_len),
		.idat_len   (idat_len),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.file_end   (file_end)
	);

`ifndef SYNTHESIS
	// the back never drops an item that the queue does not hold
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("item dropped from empty queue");

	// an accepted item is waiting in the queue in the next cycle
	a_take_held: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> q_valid)
		else $error("accepted item lost");

	// the release of the last item registers a byte marked as file end on the output
	a_end_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.last) |=> (!empty && file_end))
		else $error("file end not marked");
`endif

endmodule

### rtl/pse_front.sv
module pse_front
	import pse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        pixel_byte,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	output item_t             item,
	output logic [DIM_W-1:0]  width,
	output logic [DIM_W-1:0]  height,
	output logic [30:0]       raw_len,
	output logic [31:0]       idat_len
);

	logic [DIM_W-1:0] width_q, height_q, clamped;
	logic             in_file_q;
	logic [16:0]      col_q, col_next, width4;
	logic [DIM_W-1:0] row_q;
	logic [15:0]      row_next;
	logic             row_end, last;

	logic [31:0] raw_s1, raw_s2, y_s2;
	logic [16:0] q0_s2, q_fix;
	logic [32:0] y_sum, prod, rem;
	logic [31:0] y_full, idat_q;

	always_comb begin
		if (cfg_data == '0) begin
			clamped = 15'd1;
		end else if (cfg_data > DIM_MAX) begin
			clamped = DIM_MAX;
		end else begin
			clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 15'd1;
			height_q <= 15'd1;
		end else if (cfg_we && !in_file_q) begin
			case (cfg_index)
				REG_WIDTH:  width_q <= clamped;
				REG_HEIGHT: height_q <= clamped;
				default:    width_q <= width_q;
			endcase
		end
	end

	// classify: start of file, start of row, last byte of file
	assign width4 = {width_q, 2'b00};
	assign col_next = col_q + 17'd1;
	assign row_end = (col_next >= width4);
	assign row_next = {1'b0, row_q} + 16'd1;
	assign last = row_end && (row_next >= {1'b0, height_q});

	assign item.data = pixel_byte;
	assign item.first = !in_file_q;
	assign item.row_start = (col_q == '0);
	assign item.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_file_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			in_file_q <= !last;
			col_q <= row_end ? 17'd0 : col_next;
			if (row_end) begin
				row_q <= last ? '0 : row_next[DIM_W-1:0];
			end
		end
	end

	// raw length h*(4w+1), then ceil(raw/65535) blocks, then IDAT length
	assign y_full = raw_s1 + {16'd0, STORED_BLOCK_MAX - 16'd1};
	assign y_sum = {1'b0, y_full} + {17'd0, y_full[31:16]};
	assign prod = {q0_s2, 16'd0} - {16'd0, q0_s2};
	assign rem = {1'b0, y_s2} - prod;
	assign q_fix = (rem >= {17'd0, STORED_BLOCK_MAX}) ? q0_s2 + 17'd1 : q0_s2;

	always_ff @(posedge clk) begin
		raw_s1 <= {17'd0, height_q} * {15'd0, width4 + 17'd1};
		raw_s2 <= raw_s1;
		y_s2 <= y_full;
		q0_s2 <= y_sum[32:16];
		idat_q <= raw_s2 + {13'd0, q_fix, 2'b00} + {15'd0, q_fix} + 32'd6;
	end

	assign width = width_q;
	assign height = height_q;
	assign raw_len = raw_s2[30:0];
	assign idat_len = idat_q;

endmodule

### rtl/pse_queue.sv
module pse_queue
	import pse_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd,
	output item_t rd_item,
	output logic  valid
);

	item_t      mem_q [4];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 2'd1;
			if (rd) rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end

	assign rd_item = mem_q[rptr_q];
	assign valid = (cnt_q != '0);
	assign full = cnt_q[2];

endmodule

### rtl/pse_back.sv
module pse_back
	import pse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  logic             item_valid,
	output logic             item_pop,
	input  logic [DIM_W-1:0] width,
	input  logic [DIM_W-1:0] height,
	input  logic [30:0]      raw_len,
	input  logic [31:0]      idat_len,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       out_byte,
	output logic             file_end
);

	step_t       step_q, step_d, cur;
	logic [5:0]  pos_q, pos_d;
	logic [31:0] crc_q, crc_d, crc_out;
	logic [15:0] lo_q, hi_q, lo_d, hi_d, blk_q, blk_d, blk_len;
	logic [30:0] raw_q, raw_d;
	logic [16:0] lo_sum, hi_sum;
	logic [15:0] lo_n;
	logic [31:0] w32, h32, adler;
	logic [7:0]  byte_d, rawb;
	logic        end_d, crc_en, crc_init, out_ready, emit;
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        oend_q;

	assign w32 = {17'd0, width};
	assign h32 = {17'd0, height};
	assign crc_out = ~crc_q;
	assign adler = {hi_q, lo_q};
	assign blk_len = (raw_q < {15'd0, STORED_BLOCK_MAX}) ? raw_q[15:0] : STORED_BLOCK_MAX;
	assign rawb = (cur == ST_FILTER) ? 8'd0 : item.data;

	assign lo_sum = {1'b0, lo_q} + {9'd0, rawb};
	assign lo_n = (lo_sum >= {1'b0, ADLER_MOD}) ? lo_sum[15:0] - ADLER_MOD : lo_sum[15:0];
	assign hi_sum = {1'b0, hi_q} + {1'b0, lo_n};

	assign out_ready = !ovalid_q || pop;
	assign emit = item_valid && out_ready;

	always_comb begin
		if (step_q == ST_NEXT) begin
			cur = item.first ? ST_HEAD : (item.row_start ? ST_FILTER : ST_PIXEL);
		end else begin
			cur = step_q;
		end

		step_d = cur;
		pos_d = pos_q + 6'd1;
		byte_d = 8'd0;
		end_d = 1'b0;
		crc_en = 1'b0;
		crc_init = 1'b0;
		item_pop = 1'b0;
		lo_d = lo_q;
		hi_d = hi_q;
		blk_d = blk_q;
		raw_d = raw_q;

		case (cur)
			ST_HEAD: begin
				case (pos_q)
					6'd0:  byte_d = 8'h89;
					6'd1:  byte_d = 8'h50;
					6'd2:  byte_d = 8'h4E;
					6'd3:  byte_d = 8'h47;
					6'd4:  byte_d = 8'h0D;
					6'd5:  byte_d = 8'h0A;
					6'd6:  byte_d = 8'h1A;
					6'd7:  byte_d = 8'h0A;
					6'd11: byte_d = 8'd13;
					6'd12: byte_d = 8'h49;
					6'd13: byte_d = 8'h48;
					6'd14: byte_d = 8'h44;
					6'd15: byte_d = 8'h52;
					6'd16: byte_d = w32[31:24];
					6'd17: byte_d = w32[23:16];
					6'd18: byte_d = w32[15:8];
					6'd19: byte_d = w32[7:0];
					6'd20: byte_d = h32[31:24];
					6'd21: byte_d = h32[23:16];
					6'd22: byte_d = h32[15:8];
					6'd23: byte_d = h32[7:0];
					6'd24: byte_d = 8'd8;
					6'd25: byte_d = 8'd6;
					6'd29: byte_d = crc_out[31:24];
					6'd30: byte_d = crc_out[23:16];
					6'd31: byte_d = crc_out[15:8];
					6'd32: byte_d = crc_out[7:0];
					6'd33: byte_d = idat_len[31:24];
					6'd34: byte_d = idat_len[23:16];
					6'd35: byte_d = idat_len[15:8];
					6'd36: byte_d = idat_len[7:0];
					6'd37: byte_d = 8'h49;
					6'd38: byte_d = 8'h44;
					6'd39: byte_d = 8'h41;
					6'd40: byte_d = 8'h54;
					6'd41: byte_d = 8'h78;
					6'd42: byte_d = 8'h01;
					default: byte_d = 8'd0;
				endcase
				crc_en = (pos_q >= 6'd12 && pos_q <= 6'd28) || (pos_q >= 6'd37);
				crc_init = (pos_q == 6'd11) || (pos_q == 6'd36);
				if (pos_q == HEAD_LAST) begin
					pos_d = '0;
					step_d = item.row_start ? ST_FILTER : ST_PIXEL;
					raw_d = raw_len;
					blk_d = '0;
					lo_d = 16'd1;
					hi_d = '0;
				end
			end
			ST_FILTER, ST_PIXEL: begin
				crc_en = 1'b1;
				if (blk_q == '0) begin
					case (pos_q)
						6'd0: byte_d = {7'd0, raw_q <= {15'd0, STORED_BLOCK_MAX}};
						6'd1: byte_d = blk_len[7:0];
						6'd2: byte_d = blk_len[15:8];
						6'd3: byte_d = ~blk_len[7:0];
						default: byte_d = ~blk_len[15:8];
					endcase
					if (pos_q == BLKHDR_LAST) begin
						pos_d = '0;
						blk_d = blk_len;
					end
				end else begin
					byte_d = rawb;
					pos_d = '0;
					lo_d = lo_n;
					hi_d = (hi_sum >= {1'b0, ADLER_MOD}) ? hi_sum[15:0] - ADLER_MOD
						: hi_sum[15:0];
					blk_d = blk_q - 16'd1;
					raw_d = raw_q - 31'd1;
					if (cur == ST_FILTER) begin
						step_d = ST_PIXEL;
					end else if (item.last) begin
						step_d = ST_TAIL;
					end else begin
						step_d = ST_NEXT;
						item_pop = emit;
					end
				end
			end
			ST_TAIL: begin
				case (pos_q)
					6'd0:  byte_d = adler[31:24];
					6'd1:  byte_d = adler[23:16];
					6'd2:  byte_d = adler[15:8];
					6'd3:  byte_d = adler[7:0];
					6'd4:  byte_d = crc_out[31:24];
					6'd5:  byte_d = crc_out[23:16];
					6'd6:  byte_d = crc_out[15:8];
					6'd7:  byte_d = crc_out[7:0];
					6'd12: byte_d = 8'h49;
					6'd13: byte_d = 8'h45;
					6'd14: byte_d = 8'h4E;
					6'd15: byte_d = 8'h44;
					6'd16: byte_d = crc_out[31:24];
					6'd17: byte_d = crc_out[23:16];
					6'd18: byte_d = crc_out[15:8];
					6'd19: byte_d = crc_out[7:0];
					default: byte_d = 8'd0;
				endcase
				crc_en = (pos_q <= 6'd3) || (pos_q >= 6'd12 && pos_q <= 6'd15);
				crc_init = (pos_q == 6'd11);
				if (pos_q == TAIL_LAST) begin
					end_d = 1'b1;
					pos_d = '0;
					step_d = ST_NEXT;
					item_pop = emit;
				end
			end
			default: step_d = ST_NEXT;
		endcase

		if (crc_init) begin
			crc_d = CRC_INIT;
		end else if (crc_en) begin
			crc_d = crc_update(crc_q, byte_d);
		end else begin
			crc_d = crc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_NEXT;
			pos_q <= '0;
			crc_q <= CRC_INIT;
			lo_q <= 16'd1;
			hi_q <= '0;
			blk_q <= '0;
			raw_q <= '0;
		end else if (emit) begin
			step_q <= step_d;
			pos_q <= pos_d;
			crc_q <= crc_d;
			lo_q <= lo_d;
			hi_q <= hi_d;
			blk_q <= blk_d;
			raw_q <= raw_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_ready) begin
			ovalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q <= byte_d;
			oend_q <= end_d;
		end
	end

	assign empty = !ovalid_q;
	assign out_byte = obyte_q;
	assign file_end = oend_q;

endmodule
